// ===== sv/leb_pkg.sv =====
// shared types and constants for the leb128 varint decoder
package leb_pkg;

	localparam int DATA_W  = 8;
	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 3;
	localparam int SHIFT_W = 6;

	// longest legal encoding in bytes
	localparam logic [COUNT_W-1:0] MAX_BYTES = 3'd5;

	// payload bits per byte and the continuation flag position
	localparam int PAYLOAD_W = 7;
	localparam int CONT_BIT  = 7;

	// output form selected by the closing byte
	localparam logic [CMD_W-1:0] CMD_PLAIN     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MINUS_ONE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ZIGZAG    = 2'd2;

endpackage

// ===== sv/leb_byte_if.sv =====
// byte channel: one encoded byte and the output form command per transfer
interface leb_byte_if;
	import leb_pkg::*;

	logic               valid;
	logic               ready;
	logic [DATA_W-1:0]  data_byte;
	logic [CMD_W-1:0]   cmd;

	modport source (output valid, output data_byte, output cmd, input ready);
	modport sink (input valid, input data_byte, input cmd, output ready);
endinterface

// ===== sv/leb_result_if.sv =====
// result channel: decoded value, byte count and error flag per transfer
interface leb_result_if;
	import leb_pkg::*;

	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic [COUNT_W-1:0] byte_count;
	logic               error;

	modport source (output valid, output value, output byte_count, output error, input ready);
	modport sink (input valid, input value, input byte_count, input error, output ready);
endinterface

// ===== sv/leb128_varint_decoder_top.sv =====
// unsigned leb128 decoder for 32-bit values, one byte per transfer
//
// usage:
//   bytes  - sink channel; each transfer carries one encoded byte and cmd.
//            bit 7 of the byte set means more bytes follow. cmd on the
//            closing byte picks the output form (plain, minus one, zigzag).
//   result - source channel; one transfer per closed value, or one error
//            transfer when a fifth byte still has its continuation bit set.
// path: a closing byte is held in the input register, then its result in
//   the result register, before the result is offered on the result channel.
// throughput: one byte per cycle while the result channel does not stall,
//   through the single shift-and-or stage between the input and result registers.
// reset: arst_n clears the accumulator, the byte counter and both valid
//   flags; a partly gathered value is dropped.
// stall: while the receiver holds ready low, the result register holds.
//   continuation bytes still drain through the input register; a byte that
//   would give a result waits in the input register, and bytes.ready falls
//   only once that register is full and blocked.
module leb128_varint_decoder_top (
	input  logic clk,
	input  logic arst_n,
	leb_byte_if.sink     bytes,
	leb_result_if.source result
);
	import leb_pkg::*;

	// input register
	logic               valid_s1;
	logic [DATA_W-1:0]  data_byte_s1;
	logic [CMD_W-1:0]   cmd_s1;

	// decode state
	logic [VALUE_W-1:0] acc_q;
	logic [COUNT_W-1:0] seen_q;

	// result register
	logic               valid_s2;
	logic [VALUE_W-1:0] value_s2;
	logic [COUNT_W-1:0] count_s2;
	logic               error_s2;

	logic [SHIFT_W-1:0]           shift;
	logic [VALUE_W+PAYLOAD_W-1:0] placed;
	logic [VALUE_W-1:0]           acc_next;
	logic [COUNT_W-1:0]           count;
	logic                         closes;
	logic                         overlong;
	logic                         has_result;
	logic                         slot_free;
	logic                         consume_s1;
	logic                         take_in;
	logic [VALUE_W-1:0]           formed;

	// shift = 7 * bytes seen, as 8x - x
	assign shift    = {seen_q, 3'b000} - {3'b000, seen_q};
	assign placed   = (VALUE_W+PAYLOAD_W)'(data_byte_s1[PAYLOAD_W-1:0]) << shift;
	// payload bits landing at bit 32 or above fall off here
	assign acc_next = acc_q | placed[VALUE_W-1:0];
	assign count    = seen_q + COUNT_W'(1);

	assign closes     = !data_byte_s1[CONT_BIT];
	assign overlong   = data_byte_s1[CONT_BIT] && (count >= MAX_BYTES);
	assign has_result = closes || overlong;

	// result register can load when empty or being drained this cycle
	assign slot_free  = !valid_s2 || result.ready;
	assign consume_s1 = valid_s1 && (!has_result || slot_free);
	assign take_in    = bytes.valid && bytes.ready;

	assign bytes.ready = !valid_s1 || consume_s1;

	// output form of a closed value; an unused code reads as plain
	always_comb begin
		case (cmd_s1)
			CMD_MINUS_ONE: formed = acc_next - VALUE_W'(1);
			CMD_ZIGZAG:    formed = (acc_next >> 1) ^ {VALUE_W{acc_next[0]}};
			CMD_PLAIN:     formed = acc_next;
			default:       formed = acc_next;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			data_byte_s1 <= bytes.data_byte;
			cmd_s1       <= bytes.cmd;
		end
	end

	// accumulator and byte counter advance once per consumed continuation byte and clear on a closing or overlong one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			seen_q <= '0;
		end else if (consume_s1) begin
			if (has_result) begin
				acc_q  <= '0;
				seen_q <= '0;
			end else begin
				acc_q  <= acc_next;
				seen_q <= count;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (consume_s1 && has_result) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume_s1 && has_result) begin
			value_s2 <= closes ? formed : '0;
			count_s2 <= count;
			error_s2 <= !closes;
		end
	end

	assign result.valid      = valid_s2;
	assign result.value      = value_s2;
	assign result.byte_count = count_s2;
	assign result.error      = error_s2;

endmodule
